/* rtl/cdtp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cdtp_pkg
// Shared constants and controller/datapath interface types of the CD-TEXT
// pack parser.
// ----------------------------------------------------------------------------
package cdtp_pkg;

	localparam int MAX_STRING_CHARS_DEF = 60;

	localparam int PACK_LEN  = 18;
	localparam int TEXT_LEN  = 12;
	localparam int HDR_BYTES = 4;

	localparam logic [15:0] MIN_HEADER  = 16'd20;
	localparam logic [15:0] HEADER_ADJ  = 16'd2;
	localparam logic [15:0] PACK_LEN_16 = 16'd18;

	localparam logic [4:0] OFF_PARSE = 5'd15;
	localparam logic [4:0] OFF_LAST  = 5'd17;

	localparam logic [1:0] EV_CHAR   = 2'd0;
	localparam logic [1:0] EV_ERROR  = 2'd1;
	localparam logic [1:0] EV_FINISH = 2'd2;

	typedef struct packed {
		logic take;
		logic parse;
		logic step;
		logic push_fin;
		logic push_err;
	} ctl_cmd_t;

	typedef struct packed {
		logic go_fin;
		logic go_parse;
		logic p_fin;
		logic p_err;
		logic p_emit;
		logic e_has;
		logic e_done;
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

/* rtl/cdtp_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cdtp_datapath
// Header and pack counters, pack store, block/string tracking and the
// result register of the CD-TEXT pack parser.
// ----------------------------------------------------------------------------
module cdtp_datapath #(
	parameter int MAX_STRING_CHARS = cdtp_pkg::MAX_STRING_CHARS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [7:0]       data_byte,
	input  wire logic             first_byte,
	input  wire cdtp_pkg::ctl_cmd_t cmd,
	output cdtp_pkg::dp_status_t  st,
	input  wire logic             res_ready,
	output logic                  res_valid,
	output logic [1:0]            event_res,
	output logic [3:0]            pack_kind,
	output logic [7:0]            track_number,
	output logic [7:0]            text_char,
	output logic                  end_of_string,
	output logic                  any_saved,
	output logic                  last
);

	localparam int POS_W = $clog2(MAX_STRING_CHARS + 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_STRING_CHARS);

	logic             stop_q;
	logic [1:0]       hidx_q;
	logic             inpk_q;
	logic [4:0]       off_q;
	logic [15:0]      plen_q;
	logic [2:0]       pblk_q;
	logic             pvld_q;
	logic [POS_W-1:0] pos_q;
	logic             saved_q;
	logic             res_valid_q;

	logic [7:0]       hd_q [cdtp_pkg::HDR_BYTES];
	logic [7:0]       tx_q [cdtp_pkg::TEXT_LEN];
	logic [7:0]       trk_q;
	logic [3:0]       j_q;

	logic [1:0]       ev_q;
	logic [3:0]       kind_q;
	logic [7:0]       rtrk_q;
	logic [7:0]       chr_q;
	logic             eos_q;
	logic             sv_q;
	logic             last_q;

	logic             act;
	logic [1:0]       hidx_e;
	logic             inpk_e;
	logic [4:0]       off_e;
	logic [15:0]      hdr;
	logic [15:0]      plen_dec;
	logic [4:0]       tx_off;
	logic [3:0]       tx_idx;

	logic [2:0]       blk;
	logic             blk_chg;
	logic             type_ok;

	logic [cdtp_pkg::TEXT_LEN-1:0] nzm;
	logic [cdtp_pkg::TEXT_LEN-1:0] rest;
	logic [3:0]       end_j;
	logic [7:0]       cur;
	logic             cur_zero;
	logic             pos_room;
	logic [POS_W-1:0] pos_nx;
	logic             e_more;
	logic             push_chr;
	logic             push;

	always_comb begin
		act      = first_byte | ~stop_q;
		hidx_e   = first_byte ? 2'd0 : hidx_q;
		inpk_e   = first_byte ? 1'b0 : inpk_q;
		off_e    = first_byte ? 5'd0 : off_q;
		hdr      = {plen_q[15:8], data_byte};
		plen_dec = plen_q - cdtp_pkg::PACK_LEN_16;
		tx_off   = off_e - 5'(cdtp_pkg::HDR_BYTES);
		tx_idx   = tx_off[3:0];
	end

	always_comb begin
		type_ok = hd_q[0][7];
		blk     = hd_q[3][6:4];
		blk_chg = ~pvld_q | (blk != pblk_q);
	end

	always_comb begin
		end_j = 4'd0;
		for (int k = 0; k < cdtp_pkg::TEXT_LEN; k++) begin
			nzm[k] = tx_q[k] != 8'd0;
			if (nzm[k]) begin
				end_j = (k == cdtp_pkg::TEXT_LEN - 1) ? 4'(k) : 4'(k + 1);
			end
		end
		for (int k = 0; k < cdtp_pkg::TEXT_LEN; k++) begin
			rest[k] = (4'(k) > j_q) && (4'(k) <= end_j);
		end
		cur      = tx_q[j_q];
		cur_zero = cur == 8'd0;
		pos_room = pos_q < POS_MAX;
		if (cur_zero) begin
			pos_nx = '0;
		end else if (pos_room) begin
			pos_nx = pos_q + 1'b1;
		end else begin
			pos_nx = pos_q;
		end
		e_more = (|(rest & ~nzm)) | ((|(rest & nzm)) & (pos_nx < POS_MAX));
	end

	always_comb begin
		st.go_fin   = act & ((~inpk_e & (hidx_e == 2'd1) & (hdr < cdtp_pkg::MIN_HEADER)) |
			(inpk_e & (off_e == cdtp_pkg::OFF_LAST) & (plen_dec < cdtp_pkg::PACK_LEN_16)));
		st.go_parse = act & inpk_e & (off_e == cdtp_pkg::OFF_PARSE);
		st.p_fin    = type_ok & blk_chg & saved_q;
		st.p_err    = type_ok & ~(blk_chg & saved_q) & hd_q[3][7];
		st.p_emit   = type_ok & ~(blk_chg & saved_q) & ~hd_q[3][7] & ~hd_q[1][7];
		st.e_has    = cur_zero | pos_room;
		st.e_done   = j_q == end_j;
		st.out_free = ~res_valid_q | res_ready;
	end

	assign push_chr = cmd.step & st.e_has;
	assign push     = push_chr | cmd.push_fin | cmd.push_err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q      <= 1'b1;
			hidx_q      <= 2'd0;
			inpk_q      <= 1'b0;
			off_q       <= 5'd0;
			plen_q      <= 16'd0;
			pblk_q      <= 3'd0;
			pvld_q      <= 1'b0;
			pos_q       <= '0;
			saved_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= push | (res_valid_q & ~res_ready);
			if (cmd.take) begin
				if (first_byte) begin
					stop_q  <= 1'b0;
					pvld_q  <= 1'b0;
					pblk_q  <= 3'd0;
					pos_q   <= '0;
					saved_q <= 1'b0;
					inpk_q  <= 1'b0;
				end
				if (act) begin
					if (!inpk_e) begin
						hidx_q <= hidx_e + 2'd1;
						off_q  <= 5'd0;
						if (hidx_e == 2'd3) begin
							inpk_q <= 1'b1;
						end
						if (hidx_e == 2'd0) begin
							plen_q <= {data_byte, 8'd0};
						end else if (hidx_e == 2'd1 && hdr >= cdtp_pkg::MIN_HEADER) begin
							plen_q <= hdr - cdtp_pkg::HEADER_ADJ;
						end
					end else if (off_e == cdtp_pkg::OFF_LAST) begin
						off_q  <= 5'd0;
						plen_q <= plen_dec;
					end else begin
						off_q <= off_e + 5'd1;
					end
				end
			end
			if (cmd.parse && type_ok && blk_chg && !saved_q) begin
				pos_q  <= '0;
				pblk_q <= blk;
				pvld_q <= 1'b1;
			end
			if (push_chr) begin
				pos_q <= pos_nx;
				if (cur_zero) begin
					saved_q <= 1'b1;
				end
			end
			if (cmd.push_fin || cmd.push_err) begin
				stop_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && act && inpk_e) begin
			if (off_e < 5'(cdtp_pkg::HDR_BYTES)) begin
				hd_q[off_e[1:0]] <= data_byte;
			end else if (off_e <= cdtp_pkg::OFF_PARSE) begin
				tx_q[tx_idx] <= data_byte;
			end
		end
		if (cmd.parse) begin
			j_q   <= 4'd0;
			trk_q <= hd_q[1];
		end
		if (cmd.step) begin
			j_q <= j_q + 4'd1;
			if (cur_zero) begin
				trk_q <= trk_q + 8'd1;
			end
		end
		if (push_chr) begin
			ev_q   <= cdtp_pkg::EV_CHAR;
			kind_q <= hd_q[0][3:0];
			rtrk_q <= trk_q;
			chr_q  <= cur;
			eos_q  <= cur_zero;
			sv_q   <= 1'b0;
			last_q <= ~e_more;
		end else if (cmd.push_fin || cmd.push_err) begin
			ev_q   <= cmd.push_fin ? cdtp_pkg::EV_FINISH : cdtp_pkg::EV_ERROR;
			kind_q <= 4'd0;
			rtrk_q <= 8'd0;
			chr_q  <= 8'd0;
			eos_q  <= 1'b0;
			sv_q   <= cmd.push_fin & saved_q;
			last_q <= 1'b1;
		end
	end

	assign res_valid     = res_valid_q;
	assign event_res     = ev_q;
	assign pack_kind     = kind_q;
	assign track_number  = rtrk_q;
	assign text_char     = chr_q;
	assign end_of_string = eos_q;
	assign any_saved     = sv_q;
	assign last          = last_q;

endmodule
`default_nettype wire

/* rtl/cdtp_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cdtp_ctrl
// Sequencer of the CD-TEXT pack parser: takes words, runs the pack check and
// steps through a pack's text bytes one per cycle unless a result is held.
// ----------------------------------------------------------------------------
module cdtp_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               byte_valid,
	output logic                    byte_ready,
	input  wire cdtp_pkg::dp_status_t st,
	output cdtp_pkg::ctl_cmd_t      cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PARSE = 3'd1;
	localparam logic [2:0] S_EMIT  = 3'd2;
	localparam logic [2:0] S_FIN   = 3'd3;
	localparam logic [2:0] S_ERR   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		byte_ready   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				byte_ready = 1'b1;
				if (byte_valid) begin
					cmd.take = 1'b1;
					if (st.go_fin) begin
						state_d = S_FIN;
					end else if (st.go_parse) begin
						state_d = S_PARSE;
					end
				end
			end
			S_PARSE: begin
				cmd.parse = 1'b1;
				if (st.p_fin) begin
					state_d = S_FIN;
				end else if (st.p_err) begin
					state_d = S_ERR;
				end else if (st.p_emit) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_EMIT: begin
				if (!st.e_has || st.out_free) begin
					cmd.step = 1'b1;
					if (st.e_done) begin
						state_d = S_IDLE;
					end
				end
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.push_fin = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_ERR: begin
				if (st.out_free) begin
					cmd.push_err = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/cd_text_pack_parser_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cd_text_pack_parser_core
// CD-TEXT read response parser: one response word in, text characters,
// terminators, error and finish results out.
// ----------------------------------------------------------------------------
// A word that causes no result is only taken. The 16th word of a pack is
// taken, then the pack header is checked, then the sequencer steps through
// the text bytes one per cycle up to the last kept one (at most 12), but it
// holds a byte that makes a result while res_ready is low and a result is
// waiting. A finish at the length header or after the last whole pack is
// pushed after the word is taken; a finish or error found by the pack check
// is pushed after the check. All results go through the single result
// register.
// Results carry last on the final result caused by a word.
module cd_text_pack_parser_core #(
	parameter int MAX_STRING_CHARS = cdtp_pkg::MAX_STRING_CHARS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       first_byte,
	output logic            res_valid,
	input  wire logic       res_ready,
	output logic [1:0]      event_res,
	output logic [3:0]      pack_kind,
	output logic [7:0]      track_number,
	output logic [7:0]      text_char,
	output logic            end_of_string,
	output logic            any_saved,
	output logic            last
);

	cdtp_pkg::ctl_cmd_t   cmd;
	cdtp_pkg::dp_status_t st;

	cdtp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.st         (st),
		.cmd        (cmd)
	);

	cdtp_datapath #(
		.MAX_STRING_CHARS (MAX_STRING_CHARS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_byte     (data_byte),
		.first_byte    (first_byte),
		.cmd           (cmd),
		.st            (st),
		.res_ready     (res_ready),
		.res_valid     (res_valid),
		.event_res     (event_res),
		.pack_kind     (pack_kind),
		.track_number  (track_number),
		.text_char     (text_char),
		.end_of_string (end_of_string),
		.any_saved     (any_saved),
		.last          (last)
	);

endmodule
`default_nettype wire

/* rtl/cdtp_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cdtp_checker
// Port-level checks of the CD-TEXT pack parser result channel.
// ----------------------------------------------------------------------------
module cdtp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic [1:0] event_res,
	input wire logic [7:0] text_char,
	input wire logic       end_of_string,
	input wire logic       any_saved,
	input wire logic       last
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(event_res) &&
		$stable(text_char) && $stable(last))
		else $error("result word changed while stalled");

	a_stop_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_res != cdtp_pkg::EV_CHAR |-> last)
		else $error("finish or error result not marked last");

	a_eos_char: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && end_of_string |-> text_char == 8'd0 &&
		event_res == cdtp_pkg::EV_CHAR)
		else $error("terminator with nonzero character");

	a_saved_fin: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && any_saved |-> event_res == cdtp_pkg::EV_FINISH)
		else $error("saved flag outside finish result");

	a_char_nz: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_res == cdtp_pkg::EV_CHAR && !end_of_string |-> text_char != 8'd0)
		else $error("zero character not marked as terminator");

endmodule

bind cd_text_pack_parser_core cdtp_checker u_cdtp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res_valid),
	.res_ready     (res_ready),
	.event_res     (event_res),
	.text_char     (text_char),
	.end_of_string (end_of_string),
	.any_saved     (any_saved),
	.last          (last)
);
`default_nettype wire
